/* hdl/sfts_pkg.sv */
package sfts_pkg;

	// Flash geometry and DMA limits
	localparam int FLASH_BYTES   = 8388608;
	localparam int PAGE_BYTES    = 256;	// must be a power of two
	localparam int DMA_MAX_BYTES = 65535;

	localparam int PAGE_BITS = $clog2(PAGE_BYTES);

	// a whole page, one bit wider than the in-page offset
	localparam logic [PAGE_BITS:0] PAGE_SPAN = PAGE_BYTES[PAGE_BITS:0];

	// SPI NOR command opcodes
	localparam logic [7:0] CMD_FAST_READ    = 8'h0B;
	localparam logic [7:0] CMD_PAGE_PROGRAM = 8'h02;
	localparam logic [7:0] CMD_WRITE_ENABLE = 8'h06;
	localparam logic [7:0] CMD_READ_STATUS  = 8'h05;

	// Request function codes
	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;

	// Status codes
	localparam logic [1:0] STATUS_IDLE  = 2'd0;
	localparam logic [1:0] STATUS_BUSY  = 2'd1;
	localparam logic [1:0] STATUS_DONE  = 2'd2;
	localparam logic [1:0] STATUS_ERROR = 2'd3;

	// Action codes
	localparam logic [2:0] ACT_NONE       = 3'd0;
	localparam logic [2:0] ACT_READ_OPEN  = 3'd1;
	localparam logic [2:0] ACT_READ_NEXT  = 3'd2;
	localparam logic [2:0] ACT_READ_STOP  = 3'd3;
	localparam logic [2:0] ACT_PAGE_PROG  = 3'd4;
	localparam logic [2:0] ACT_PAGE_STOP  = 3'd5;
	localparam logic [2:0] ACT_WREN_ONLY  = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_READ_DMA = 3'd1,
		ST_WR_READY = 3'd2,
		ST_WR_DMA   = 3'd3,
		ST_WR_BUSY  = 3'd4,
		ST_DONE     = 3'd5,
		ST_ERROR    = 3'd6
	} stage_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [23:0] start_addr;
		logic [23:0] word_count;
		logic        flash_busy;
		logic        write_enabled;
		logic        dma_done;
		logic        spi_busy;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  action;
		logic [23:0] flash_addr;
		logic [23:0] buffer_offset;
		logic [15:0] chunk_len;
	} rsp_t;

	typedef struct packed {
		stage_t      stage;
		logic [23:0] cur_addr;
		logic [24:0] bytes_left;
		logic [15:0] cur_chunk;
		logic [24:0] offset_done;
	} xfer_state_t;

endpackage

/* hdl/spi_flash_transfer_sequencer_core.sv */
// SPI NOR transfer sequencer: one request in, one result out.
// A request taken into the input register is evaluated against the transfer state and
// lands in the result register once that register is free or draining, and is offered
// from there; while the result register is full the request waits in the input register.
// Throughput: one request per cycle while results are taken; set by the single
// input-to-result register pass. Reset clears the transfer state to idle, no results.
module spi_flash_transfer_sequencer_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sfts_pkg::req_t   in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output sfts_pkg::rsp_t   out_item
);

	logic                  valid_s1;
	sfts_pkg::req_t        req_s1;
	sfts_pkg::xfer_state_t state_q;
	sfts_pkg::xfer_state_t state_nxt;
	sfts_pkg::rsp_t        rsp_nxt;
	sfts_pkg::rsp_t        rsp_q;
	logic                  rsp_valid_q;
	logic                  commit;

	sfts_step u_step (
		.req (req_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.rsp (rsp_nxt)
	);

	// The held request retires whenever the result register is free or draining
	assign commit   = valid_s1 && (!rsp_valid_q || out_ready);
	assign in_ready = !valid_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			state_q     <= '{stage: sfts_pkg::ST_IDLE, default: '0};
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (commit) begin
				state_q     <= state_nxt;
				rsp_valid_q <= 1'b1;
			end else if (out_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_item;
		end
		if (commit) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign out_valid = rsp_valid_q;
	assign out_item  = rsp_q;

endmodule

/* hdl/sfts_step.sv */
module sfts_step (
	input  sfts_pkg::req_t        req,
	input  sfts_pkg::xfer_state_t cur,
	output sfts_pkg::xfer_state_t nxt,
	output sfts_pkg::rsp_t        rsp
);

	logic [25:0]              blen;
	logic [25:0]              addr_w;
	logic [25:0]              last_byte;
	logic                     in_flight;
	logic                     bad_range;
	logic [23:0]              adv_addr;
	logic [24:0]              adv_off;
	logic [24:0]              adv_left;
	logic [15:0]              dma_chunk;
	logic [sfts_pkg::PAGE_BITS:0] page_room;
	logic [15:0]              page_chunk;
	logic [2:0]               act;
	logic [23:0]              r_addr;
	logic [23:0]              r_off;
	logic [15:0]              r_len;

	assign blen      = {1'b0, req.word_count, 1'b0};
	assign addr_w    = {2'b00, req.start_addr};
	assign last_byte = 26'(sfts_pkg::FLASH_BYTES - 1);
	assign in_flight = (cur.stage != sfts_pkg::ST_IDLE) && (cur.stage != sfts_pkg::ST_DONE)
		&& (cur.stage != sfts_pkg::ST_ERROR);
	assign bad_range = (blen > 26'(sfts_pkg::FLASH_BYTES)) || (addr_w > last_byte)
		|| ((blen - 26'd1) > (last_byte - addr_w));

	// Move past the chunk just finished
	assign adv_addr = cur.cur_addr + {8'd0, cur.cur_chunk};
	assign adv_off  = cur.offset_done + {9'd0, cur.cur_chunk};
	assign adv_left = (cur.bytes_left >= {9'd0, cur.cur_chunk})
		? (cur.bytes_left - {9'd0, cur.cur_chunk}) : 25'd0;
	assign dma_chunk = (adv_left >= 25'(sfts_pkg::DMA_MAX_BYTES))
		? 16'(sfts_pkg::DMA_MAX_BYTES) : adv_left[15:0];

	// Bytes up to the next page boundary
	assign page_room = sfts_pkg::PAGE_SPAN
		- {1'b0, cur.cur_addr[sfts_pkg::PAGE_BITS-1:0]};
	assign page_chunk = (cur.bytes_left < 25'(page_room))
		? cur.bytes_left[15:0] : 16'(page_room);

	always_comb begin
		nxt    = cur;
		act    = sfts_pkg::ACT_NONE;
		r_addr = '0;
		r_off  = '0;
		r_len  = '0;
		case (req.func)
			sfts_pkg::FUNC_READ, sfts_pkg::FUNC_WRITE: begin
				if (in_flight) begin
					nxt.stage = sfts_pkg::ST_ERROR;
				end else if (req.word_count == 24'd0) begin
					nxt.stage = sfts_pkg::ST_DONE;
				end else if (bad_range || req.spi_busy) begin
					nxt.stage = sfts_pkg::ST_ERROR;
				end else begin
					nxt.cur_addr    = req.start_addr;
					nxt.bytes_left  = blen[24:0];
					nxt.offset_done = '0;
					if (req.func == sfts_pkg::FUNC_READ) begin
						nxt.cur_chunk = (blen >= 26'(sfts_pkg::DMA_MAX_BYTES))
							? 16'(sfts_pkg::DMA_MAX_BYTES) : blen[15:0];
						nxt.stage = sfts_pkg::ST_READ_DMA;
						act    = sfts_pkg::ACT_READ_OPEN;
						r_addr = req.start_addr;
						r_len  = nxt.cur_chunk;
					end else begin
						nxt.cur_chunk = '0;
						nxt.stage     = sfts_pkg::ST_WR_READY;
					end
				end
			end
			sfts_pkg::FUNC_TICK: begin
				case (cur.stage)
					sfts_pkg::ST_READ_DMA: begin
						if (req.dma_done && !req.spi_busy) begin
							nxt.cur_addr    = adv_addr;
							nxt.offset_done = adv_off;
							nxt.bytes_left  = adv_left;
							if (adv_left == 25'd0) begin
								nxt.stage = sfts_pkg::ST_DONE;
								act    = sfts_pkg::ACT_READ_STOP;
								r_addr = cur.cur_addr;
								r_off  = cur.offset_done[23:0];
								r_len  = cur.cur_chunk;
							end else begin
								nxt.cur_chunk = dma_chunk;
								act    = sfts_pkg::ACT_READ_NEXT;
								r_addr = adv_addr;
								r_off  = adv_off[23:0];
								r_len  = dma_chunk;
							end
						end
					end
					sfts_pkg::ST_WR_READY: begin
						if (!req.flash_busy) begin
							nxt.cur_chunk = page_chunk;
							if (page_chunk == 16'd0) begin
								nxt.stage = sfts_pkg::ST_ERROR;
							end else begin
								r_addr = cur.cur_addr;
								r_off  = cur.offset_done[23:0];
								r_len  = page_chunk;
								if (!req.write_enabled) begin
									// WEL never latched: give up on the transfer
									nxt.stage = sfts_pkg::ST_ERROR;
									act       = sfts_pkg::ACT_WREN_ONLY;
								end else begin
									nxt.stage = sfts_pkg::ST_WR_DMA;
									act       = sfts_pkg::ACT_PAGE_PROG;
								end
							end
						end
					end
					sfts_pkg::ST_WR_DMA: begin
						if (req.dma_done && !req.spi_busy) begin
							nxt.stage = sfts_pkg::ST_WR_BUSY;
							act    = sfts_pkg::ACT_PAGE_STOP;
							r_addr = cur.cur_addr;
							r_off  = cur.offset_done[23:0];
							r_len  = cur.cur_chunk;
						end
					end
					sfts_pkg::ST_WR_BUSY: begin
						if (!req.flash_busy) begin
							nxt.cur_addr    = adv_addr;
							nxt.offset_done = adv_off;
							nxt.bytes_left  = adv_left;
							nxt.stage = (adv_left == 25'd0) ? sfts_pkg::ST_DONE
								: sfts_pkg::ST_WR_READY;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (nxt.stage)
			sfts_pkg::ST_IDLE:  rsp.status = sfts_pkg::STATUS_IDLE;
			sfts_pkg::ST_DONE:  rsp.status = sfts_pkg::STATUS_DONE;
			sfts_pkg::ST_ERROR: rsp.status = sfts_pkg::STATUS_ERROR;
			default:            rsp.status = sfts_pkg::STATUS_BUSY;
		endcase
		rsp.action        = act;
		rsp.flash_addr    = r_addr;
		rsp.buffer_offset = r_off;
		rsp.chunk_len     = r_len;
	end

endmodule

/* verif/spi_flash_transfer_sequencer_core_test.sv */
module spi_flash_transfer_sequencer_core_test;
	import sfts_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned RUN_ITEMS  = 1700;
	localparam int unsigned PAUSE_EVERY = 400;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_item;

	spi_flash_transfer_sequencer_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	req_t pending_reqs[$];
	rsp_t predicted_rsps[$];

	// shadow of the transfer state
	stage_t      xf_stage = ST_IDLE;
	logic [23:0] xf_addr  = '0;
	logic [24:0] xf_left  = '0;
	logic [15:0] xf_chunk = '0;
	logic [24:0] xf_done  = '0;

	bit calm = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned n_queued = 0;
	int unsigned n_driven = 0;
	int unsigned n_checked = 0;
	int unsigned n_fail = 0;
	int unsigned act_seen[8];
	int unsigned n_errors_seen = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 1500000);
		$display("simulation failed");
		$finish;
	end

	function automatic int unsigned min_of(int unsigned a, int unsigned b);
		return (a < b) ? a : b;
	endfunction

	function automatic int unsigned idle_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic rsp_t make_rsp(logic [2:0] act, logic [23:0] fa, logic [23:0] off,
			logic [15:0] len);
		rsp_t r;
		case (xf_stage)
			ST_IDLE:  r.status = STATUS_IDLE;
			ST_DONE:  r.status = STATUS_DONE;
			ST_ERROR: r.status = STATUS_ERROR;
			default:  r.status = STATUS_BUSY;
		endcase
		r.action        = act;
		r.flash_addr    = fa;
		r.buffer_offset = off;
		r.chunk_len     = len;
		return r;
	endfunction

	function automatic void advance_chunk();
		xf_addr = xf_addr + xf_chunk;
		xf_done = xf_done + xf_chunk;
		xf_left = (xf_left >= xf_chunk) ? xf_left - xf_chunk : '0;
	endfunction

	// result of one request, updating the shadow state
	function automatic rsp_t sequencer_result(req_t rq);
		int unsigned blen, addr, lim;
		logic [23:0] fa, off;
		logic [15:0] len;
		blen = int'(rq.word_count) * 2;
		addr = rq.start_addr;
		lim  = FLASH_BYTES - 1;
		fa   = xf_addr;
		off  = xf_done[23:0];
		len  = xf_chunk;
		if (rq.func == FUNC_READ || rq.func == FUNC_WRITE) begin
			if (!(xf_stage inside {ST_IDLE, ST_DONE, ST_ERROR})) begin
				xf_stage = ST_ERROR;
			end else if (blen == 0) begin
				xf_stage = ST_DONE;
			end else if (blen > FLASH_BYTES || addr > lim || blen - 1 > lim - addr ||
					rq.spi_busy) begin
				xf_stage = ST_ERROR;
			end else begin
				xf_addr = rq.start_addr;
				xf_left = 25'(blen);
				xf_done = '0;
				if (rq.func == FUNC_READ) begin
					xf_chunk = 16'(min_of(blen, DMA_MAX_BYTES));
					xf_stage = ST_READ_DMA;
					return make_rsp(ACT_READ_OPEN, xf_addr, '0, xf_chunk);
				end
				xf_chunk = '0;
				xf_stage = ST_WR_READY;
			end
		end else if (rq.func == FUNC_TICK) begin
			case (xf_stage)
				ST_READ_DMA: if (rq.dma_done && !rq.spi_busy) begin
					advance_chunk();
					if (xf_left == 0) begin
						xf_stage = ST_DONE;
						return make_rsp(ACT_READ_STOP, fa, off, len);
					end
					xf_chunk = 16'(min_of(xf_left, DMA_MAX_BYTES));
					return make_rsp(ACT_READ_NEXT, xf_addr, xf_done[23:0], xf_chunk);
				end
				ST_WR_READY: if (!rq.flash_busy) begin
					xf_chunk = 16'(min_of(xf_left, PAGE_BYTES - (xf_addr % PAGE_BYTES)));
					if (xf_chunk == 0) begin
						xf_stage = ST_ERROR;
					end else if (!rq.write_enabled) begin
						xf_stage = ST_ERROR;
						return make_rsp(ACT_WREN_ONLY, xf_addr, xf_done[23:0], xf_chunk);
					end else begin
						xf_stage = ST_WR_DMA;
						return make_rsp(ACT_PAGE_PROG, xf_addr, xf_done[23:0], xf_chunk);
					end
				end
				ST_WR_DMA: if (rq.dma_done && !rq.spi_busy) begin
					xf_stage = ST_WR_BUSY;
					return make_rsp(ACT_PAGE_STOP, fa, off, len);
				end
				ST_WR_BUSY: if (!rq.flash_busy) begin
					advance_chunk();
					xf_stage = (xf_left == 0) ? ST_DONE : ST_WR_READY;
				end
				default: ;
			endcase
		end
		return make_rsp(ACT_NONE, '0, '0, '0);
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predicted_rsps.push_back(sequencer_result(in_item));
				n_driven++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || pending_reqs.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					in_item  <= pending_reqs.pop_front();
					in_valid <= 1'b1;
					gap_left = idle_gap();
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_checked++;
				act_seen[out_item.action]++;
				if (out_item.status == STATUS_ERROR)
					n_errors_seen++;
				if (predicted_rsps.size() == 0) begin
					$error("result with nothing outstanding: %p", out_item);
					n_fail++;
				end else begin
					want = predicted_rsps.pop_front();
					if (out_item.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_item.status);
						n_fail++;
					end
					if (out_item.action !== want.action) begin
						$error("action: expected %0d, got %0d", want.action, out_item.action);
						n_fail++;
					end
					if (out_item.flash_addr !== want.flash_addr) begin
						$error("flash_addr: expected %h, got %h", want.flash_addr,
							out_item.flash_addr);
						n_fail++;
					end
					if (out_item.buffer_offset !== want.buffer_offset) begin
						$error("buffer_offset: expected %h, got %h", want.buffer_offset,
							out_item.buffer_offset);
						n_fail++;
					end
					if (out_item.chunk_len !== want.chunk_len) begin
						$error("chunk_len: expected %0d, got %0d", want.chunk_len,
							out_item.chunk_len);
						n_fail++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left = ($urandom_range(0, 3) == 0) ? idle_gap() : 0;
			end
		end
	end

	function automatic bit rbit();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic send(logic [1:0] f, logic [23:0] a, logic [23:0] wc, bit fb, bit we,
			bit dd, bit sb);
		req_t r;
		r.func          = f;
		r.start_addr    = a;
		r.word_count    = wc;
		r.flash_busy    = fb;
		r.write_enabled = we;
		r.dma_done      = dd;
		r.spi_busy      = sb;
		pending_reqs.push_back(r);
		n_queued++;
	endtask

	task automatic tick(bit fb, bit we, bit dd, bit sb);
		send(FUNC_TICK, $urandom, $urandom, fb, we, dd, sb);
	endtask

	// tick on which the DMA has not finished, or the shifter still runs
	task automatic dma_wait_ticks();
		repeat ($urandom_range(0, 2)) begin
			if (rbit())
				tick(rbit(), rbit(), 1'b0, rbit());
			else
				tick(rbit(), rbit(), 1'b1, 1'b1);
		end
	endtask

	task automatic read_transfer();
		int unsigned r, wc, addr, chunks;
		r = $urandom_range(0, 99);
		if (r < 70)
			wc = $urandom_range(1, 200);
		else if (r < 92)
			wc = $urandom_range(1, 100000);
		else
			wc = $urandom_range(1, FLASH_BYTES / 2);
		addr = ($urandom_range(0, 9) == 0) ? FLASH_BYTES - 2 * wc
			: $urandom_range(0, FLASH_BYTES - 2 * wc);
		send(FUNC_READ, addr, wc, rbit(), rbit(), rbit(), 1'b0);
		chunks = (2 * wc + DMA_MAX_BYTES - 1) / DMA_MAX_BYTES;
		repeat (chunks) begin
			dma_wait_ticks();
			tick(rbit(), rbit(), 1'b1, 1'b0);
		end
	endtask

	task automatic write_transfer();
		int unsigned r, wc, addr, left, chunk, near_end;
		bit we;
		r = $urandom_range(0, 99);
		if (r < 80)
			wc = $urandom_range(1, 150);
		else if (r < 97)
			wc = $urandom_range(1, 700);
		else
			wc = $urandom_range(1, 4000);
		addr = $urandom_range(0, FLASH_BYTES - 2 * wc);
		// start just short of a page boundary now and then
		near_end = (addr | (PAGE_BYTES - 1)) - $urandom_range(0, 7);
		if (rbit() && near_end + 2 * wc <= FLASH_BYTES)
			addr = near_end;
		send(FUNC_WRITE, addr, wc, rbit(), rbit(), rbit(), 1'b0);
		left = 2 * wc;
		while (left > 0) begin
			repeat ($urandom_range(0, 2))
				tick(1'b1, rbit(), rbit(), rbit());
			we = ($urandom_range(0, 19) != 0);
			tick(1'b0, we, rbit(), rbit());
			if (!we)
				return;
			dma_wait_ticks();
			tick(rbit(), rbit(), 1'b1, 1'b0);
			repeat ($urandom_range(0, 2))
				tick(1'b1, rbit(), rbit(), rbit());
			tick(1'b0, rbit(), rbit(), rbit());
			chunk = min_of(left, PAGE_BYTES - (addr % PAGE_BYTES));
			addr += chunk;
			left -= chunk;
		end
	endtask

	task automatic malformed_request();
		logic [1:0] f;
		f = rbit() ? FUNC_WRITE : FUNC_READ;
		case ($urandom_range(0, 5))
			0: send($urandom_range(0, 3), $urandom, $urandom, rbit(), rbit(), rbit(), rbit());
			1: send(f, $urandom_range(0, FLASH_BYTES / 2), $urandom_range(1, 64),
				rbit(), rbit(), rbit(), 1'b1);
			2: send(f, $urandom_range(FLASH_BYTES, 24'hFFFFFF), $urandom, rbit(), rbit(),
				rbit(), 1'b0);
			3: send(f, $urandom, $urandom_range(FLASH_BYTES / 2 + 1, 24'hFFFFFF), rbit(),
				rbit(), rbit(), 1'b0);
			4: send(f, $urandom, 24'd0, rbit(), rbit(), rbit(), rbit());
			default: begin
				// a new start lands on a transfer in flight
				send(f, $urandom_range(0, FLASH_BYTES / 2), $urandom_range(1, 300), 1'b0,
					1'b1, 1'b0, 1'b0);
				repeat ($urandom_range(0, 3))
					tick(rbit(), rbit(), rbit(), rbit());
				send(rbit() ? FUNC_WRITE : FUNC_READ, $urandom, $urandom, rbit(), rbit(),
					rbit(), rbit());
			end
		endcase
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid)
			@(posedge clk);
		while (predicted_rsps.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned rand_base, next_pause, phase, r;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		tick(1'b1, 1'b1, 1'b1, 1'b1);
		send(FUNC_UNUSED, 24'h123456, 24'h000010, 1'b0, 1'b1, 1'b0, 1'b1);
		send(FUNC_WRITE, 24'h000100, 24'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		send(FUNC_READ, 24'd0, 24'hFFFFFF, 1'b0, 1'b0, 1'b0, 1'b0);
		send(FUNC_READ, 24'hFFFFFF, 24'd1, 1'b0, 1'b0, 1'b0, 1'b0);
		send(FUNC_WRITE, FLASH_BYTES - 2, 24'd2, 1'b0, 1'b0, 1'b0, 1'b0);
		send(FUNC_READ, 24'd0, 24'd1, 1'b0, 1'b0, 1'b0, 1'b1);
		// last two bytes of the array
		send(FUNC_READ, FLASH_BYTES - 2, 24'd1, 1'b1, 1'b1, 1'b1, 1'b0);
		tick(1'b0, 1'b0, 1'b1, 1'b1);
		tick(1'b0, 1'b0, 1'b1, 1'b0);
		// whole array, then a start on top of it
		send(FUNC_READ, 24'd0, FLASH_BYTES / 2, 1'b0, 1'b0, 1'b0, 1'b0);
		tick(1'b0, 1'b0, 1'b1, 1'b0);
		send(FUNC_WRITE, 24'h000010, 24'd4, 1'b0, 1'b0, 1'b0, 1'b0);
		tick(1'b0, 1'b1, 1'b1, 1'b0);
		// four bytes across a page boundary, WEL lost on the second page
		send(FUNC_WRITE, 24'h0000FE, 24'd2, 1'b0, 1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b1, 1'b1, 1'b0);
		tick(1'b0, 1'b1, 1'b0, 1'b0);
		tick(1'b0, 1'b0, 1'b0, 1'b0);
		tick(1'b0, 1'b0, 1'b1, 1'b0);
		tick(1'b1, 1'b0, 1'b0, 1'b0);
		tick(1'b0, 1'b0, 1'b0, 1'b0);
		tick(1'b0, 1'b0, 1'b0, 1'b0);
		send(FUNC_READ, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		drain();

		rand_base  = n_queued;
		next_pause = PAUSE_EVERY;
		phase      = 0;
		while (n_queued - rand_base < RUN_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				read_transfer();
			else if (r < 80)
				write_transfer();
			else
				malformed_request();
			if (n_queued - rand_base >= next_pause) begin
				drain();
				phase++;
				calm = (phase % 3 == 1);
				next_pause += PAUSE_EVERY;
			end
		end
		drain();
		repeat (10) @(posedge clk);
		if (predicted_rsps.size() != 0) begin
			$error("%0d results never arrived", predicted_rsps.size());
			n_fail++;
		end

		$display("%0d requests, %0d results: %0d read chunks, %0d pages programmed,",
			n_driven, n_checked, act_seen[ACT_READ_OPEN] + act_seen[ACT_READ_NEXT],
			act_seen[ACT_PAGE_PROG]);
		$display("%0d WEL refusals, %0d results reporting error status",
			act_seen[ACT_WREN_ONLY], n_errors_seen);
		if (n_fail == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
